>>> src/i2cb_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Depends on nothing; every other file of the block imports it.
package i2cb_pkg;

  localparam int unsigned RegW = 8;
  localparam int unsigned BitIdxW = 4;
  localparam logic [BitIdxW-1:0] BitsPerByte = BitIdxW'(8);

  // Command codes carried in the func field
  typedef enum logic [2:0] {
    FUNC_NONE     = 3'd0,
    FUNC_START    = 3'd1,
    FUNC_STOP     = 3'd2,
    FUNC_WRITE    = 3'd3,
    FUNC_READ     = 3'd4,
    FUNC_WAIT_ACK = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_STOP_DELAY = 2'd0,
    CFG_BIT_DELAY        = 2'd1,
    CFG_SAMPLE_DELAY     = 2'd2,
    CFG_ACK_TIMEOUT      = 2'd3
  } cfg_idx_e;

  localparam logic [RegW-1:0] StartStopDelayRst = RegW'(4);
  localparam logic [RegW-1:0] BitDelayRst       = RegW'(2);
  localparam logic [RegW-1:0] SampleDelayRst    = RegW'(1);
  localparam logic [RegW-1:0] AckTimeoutRst     = RegW'(250);

  // Bus sequencer steps, one-hot
  typedef enum logic [14:0] {
    PH_IDLE = 15'b000000000000001,
    PH_ST1  = 15'b000000000000010,
    PH_ST2  = 15'b000000000000100,
    PH_SP1  = 15'b000000000001000,
    PH_SP2  = 15'b000000000010000,
    PH_WA   = 15'b000000000100000,
    PH_WB   = 15'b000000001000000,
    PH_WC   = 15'b000000010000000,
    PH_RA   = 15'b000000100000000,
    PH_RB   = 15'b000001000000000,
    PH_AA   = 15'b000010000000000,
    PH_AB   = 15'b000100000000000,
    PH_K1   = 15'b001000000000000,
    PH_K2   = 15'b010000000000000,
    PH_K3   = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    logic [RegW-1:0] start_stop_delay;
    logic [RegW-1:0] bit_delay;
    logic [RegW-1:0] sample_delay;
    logic [RegW-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [RegW-1:0] tx_byte;
    logic            send_ack;
    logic            sda_in;
  } in_item_t;

  typedef struct packed {
    logic            scl;
    logic            sda_out;
    logic            sda_drive;
    logic            busy_res;
    logic            done_res;
    logic [RegW-1:0] rx_byte;
    logic            ack_missing;
  } out_item_t;

  // A zero hold still lasts one tick
  function automatic logic [RegW-1:0] hold_of(logic [RegW-1:0] h);
    return (h == '0) ? RegW'(1) : h;
  endfunction

endpackage

>>> src/i2cb_if.sv
// Valid/ready stream interfaces for tick items and result items.
// Depends on i2cb_pkg for the payload types.
interface i2cb_in_if;
  import i2cb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cb_out_if;
  import i2cb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/i2c_bitbang_master.sv
// I2C master bit engine top level: input register, tick engine, result register.
// Each tick passes the input register, then the result register; throughput 1 tick per cycle while results are taken.
// Input stalls only when both the input and the result registers are full and the result is not taken.
// Reset (async, active low) empties both registers, idles the engine with SCL/SDA
// driven high and loads the default delays. Depends on i2cb_pkg, i2cb_if,
// i2cb_cfg and i2cb_engine.
module i2c_bitbang_master (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  i2cb_in_if.sink                   in_i,
  i2cb_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [i2cb_pkg::RegW-1:0] cfg_data_i
);
  import i2cb_pkg::*;

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      step;
  cfg_t      cfg;
  out_item_t res;

  // the held tick moves on whenever the result register can take its result
  assign step = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  i2cb_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  i2cb_engine u_engine (
    .clk_i,
    .rst_ni,
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (step) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_item_q <= in_i.data;
    if (step) out_item_q <= res;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

endmodule

>>> src/i2cb_cfg.sv
// Configuration register file: four 8-bit delay/timeout registers.
// Depends on i2cb_pkg.
module i2cb_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [i2cb_pkg::RegW-1:0] cfg_data_i,
  output i2cb_pkg::cfg_t         cfg_o
);
  import i2cb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_STOP_DELAY: cfg_d.start_stop_delay = cfg_data_i;
        CFG_BIT_DELAY:        cfg_d.bit_delay        = cfg_data_i;
        CFG_SAMPLE_DELAY:     cfg_d.sample_delay     = cfg_data_i;
        CFG_ACK_TIMEOUT:      cfg_d.ack_timeout      = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_stop_delay <= StartStopDelayRst;
      cfg_q.bit_delay        <= BitDelayRst;
      cfg_q.sample_delay     <= SampleDelayRst;
      cfg_q.ack_timeout      <= AckTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/i2cb_engine.sv
// Bit engine state and one-tick next-state logic; the result reflects
// the state after the tick. Depends on i2cb_pkg.
module i2cb_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cb_pkg::in_item_t   item_i,
  input  i2cb_pkg::cfg_t       cfg_i,
  output i2cb_pkg::out_item_t  res_o
);
  import i2cb_pkg::*;

  phase_e              phase_q, phase_d;
  logic [RegW-1:0]     delay_q, delay_d;
  logic [BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [RegW-1:0]     shift_q, shift_d;
  logic [RegW-1:0]     wait_q, wait_d;
  logic                ack_choice_q, ack_choice_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                sda_en_q, sda_en_d;
  logic                ack_flag_q, ack_flag_d;
  logic [RegW-1:0]     rx_q, rx_d;
  logic                done;
  logic [RegW-1:0]     delay_dec;

  always_comb begin
    phase_d      = phase_q;
    delay_d      = delay_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    wait_d       = wait_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    sda_en_d     = sda_en_q;
    ack_flag_d   = ack_flag_q;
    rx_d         = rx_q;
    done         = 1'b0;
    delay_dec    = (delay_q != '0) ? delay_q - RegW'(1) : delay_q;

    if (phase_q == PH_IDLE) begin
      unique case (item_i.func)
        FUNC_START: begin
          sda_en_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          phase_d = PH_ST1; delay_d = hold_of(cfg_i.start_stop_delay);
        end
        FUNC_STOP: begin
          sda_en_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          phase_d = PH_SP1; delay_d = hold_of(cfg_i.start_stop_delay);
        end
        FUNC_WRITE: begin
          sda_en_d = 1'b1; scl_d = 1'b0; bit_idx_d = '0;
          sda_d = item_i.tx_byte[RegW-1];
          shift_d = {item_i.tx_byte[RegW-2:0], 1'b0};
          phase_d = PH_WA; delay_d = hold_of(cfg_i.bit_delay);
        end
        FUNC_READ: begin
          sda_en_d = 1'b0; scl_d = 1'b0; shift_d = '0; bit_idx_d = '0;
          ack_choice_d = item_i.send_ack;
          phase_d = PH_RA; delay_d = hold_of(cfg_i.bit_delay);
        end
        FUNC_WAIT_ACK: begin
          sda_en_d = 1'b0; sda_d = 1'b1; wait_d = '0; ack_flag_d = 1'b0;
          phase_d = PH_K1; delay_d = hold_of(cfg_i.sample_delay);
        end
        default: ;
      endcase
    end else if (phase_q == PH_K3) begin
      priority if (!item_i.sda_in) begin
        scl_d = 1'b0; ack_flag_d = 1'b0;
        phase_d = PH_IDLE; delay_d = '0; done = 1'b1;
      end else if (wait_q >= cfg_i.ack_timeout) begin
        // no ACK: flag it and release the bus with a stop
        ack_flag_d = 1'b1;
        sda_en_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
        phase_d = PH_SP1; delay_d = hold_of(cfg_i.start_stop_delay);
      end else begin
        wait_d = wait_q + RegW'(1);
      end
    end else begin
      delay_d = delay_dec;
      if (delay_dec == '0) begin
        unique case (phase_q)
          PH_ST1: begin
            sda_d = 1'b0;
            phase_d = PH_ST2; delay_d = hold_of(cfg_i.start_stop_delay);
          end
          PH_SP1: begin
            scl_d = 1'b1; sda_d = 1'b1;
            phase_d = PH_SP2; delay_d = hold_of(cfg_i.start_stop_delay);
          end
          PH_WA: begin
            scl_d = 1'b1; phase_d = PH_WB; delay_d = hold_of(cfg_i.bit_delay);
          end
          PH_WB: begin
            scl_d = 1'b0; phase_d = PH_WC; delay_d = hold_of(cfg_i.bit_delay);
          end
          PH_WC: begin
            bit_idx_d = bit_idx_q + BitIdxW'(1);
            if (bit_idx_d >= BitsPerByte) begin
              phase_d = PH_IDLE; delay_d = '0; done = 1'b1;
            end else begin
              sda_d = shift_q[RegW-1];
              shift_d = {shift_q[RegW-2:0], 1'b0};
              phase_d = PH_WA; delay_d = hold_of(cfg_i.bit_delay);
            end
          end
          PH_RA: begin
            // sample on the tick SCL rises
            scl_d = 1'b1;
            shift_d = {shift_q[RegW-2:0], item_i.sda_in};
            bit_idx_d = bit_idx_q + BitIdxW'(1);
            phase_d = PH_RB; delay_d = hold_of(cfg_i.sample_delay);
          end
          PH_RB: begin
            scl_d = 1'b0;
            if (bit_idx_q >= BitsPerByte) begin
              rx_d = shift_q;
              sda_en_d = 1'b1;
              sda_d = ~ack_choice_q;
              phase_d = PH_AA; delay_d = hold_of(cfg_i.bit_delay);
            end else begin
              phase_d = PH_RA; delay_d = hold_of(cfg_i.bit_delay);
            end
          end
          PH_AA: begin
            scl_d = 1'b1; phase_d = PH_AB; delay_d = hold_of(cfg_i.bit_delay);
          end
          PH_AB: begin
            scl_d = 1'b0; phase_d = PH_IDLE; delay_d = '0; done = 1'b1;
          end
          PH_ST2: begin
            scl_d = 1'b0; phase_d = PH_IDLE; delay_d = '0; done = 1'b1;
          end
          PH_K1: begin
            scl_d = 1'b1; phase_d = PH_K2; delay_d = hold_of(cfg_i.sample_delay);
          end
          PH_K2: begin
            phase_d = PH_K3; delay_d = RegW'(1);
          end
          default: begin
            // stop's last step and anything else end the command
            phase_d = PH_IDLE; delay_d = '0; done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      delay_q      <= '0;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      wait_q       <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      sda_en_q     <= 1'b1;
      ack_flag_q   <= 1'b0;
      rx_q         <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      delay_q      <= delay_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      wait_q       <= wait_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      sda_en_q     <= sda_en_d;
      ack_flag_q   <= ack_flag_d;
      rx_q         <= rx_d;
    end
  end

  assign res_o.scl         = scl_d;
  assign res_o.sda_out     = sda_d;
  assign res_o.sda_drive   = sda_en_d;
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.rx_byte     = rx_d;
  assign res_o.ack_missing = ack_flag_d;

endmodule

>>> src/i2cb_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends on i2cb_pkg and i2c_bitbang_master.
module i2cb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input i2cb_pkg::out_item_t out_data_i
);
  import i2cb_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // the input side only stalls behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with result register free");

  // a completing command leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.done_res |-> !out_data_i.busy_res)
    else $error("done reported while busy");

  // a tick taken while the result register is empty yields a valid result once it has passed both registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> ##1 out_valid_i)
    else $error("result missing after input transfer");

endmodule

bind i2c_bitbang_master i2cb_checker u_i2cb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
